### sv/fasmd_pkg.sv
// ----------------------------------------------------------------------------
// fasmd_pkg
// Shared types, operation codes and helper functions of the binary32
// add / subtract / multiply / divide pipeline.
// ----------------------------------------------------------------------------
package fasmd_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [31:0] QNAN_BITS = 32'h7fc0_0000;
    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [30:0] INF_MAG   = 31'h7f80_0000;

    // quotient bits produced by the restoring divider, one per stage
    localparam int DIV_BITS = 28;

    // front end and divider record
    typedef struct packed {
        logic               valid;
        logic [1:0]         op;
        logic               spec;
        logic [31:0]        spec_bits;
        logic               status;
        logic               sign;
        logic               sign_b;
        logic [7:0]         exa;
        logic [7:0]         exb;
        logic [4:0]         lza;
        logic [4:0]         lzb;
        logic [26:0]        ma;
        logic [26:0]        mb;
        logic [24:0]        rem;
        logic [47:0]        prod;
        logic signed [10:0] exp;
        logic [27:0]        mant;
    } pipe_t;

    // unrounded result: value = mant * 2^(exp - 154), sticky folded into bit 0
    typedef struct packed {
        logic               valid;
        logic               spec;
        logic [31:0]        spec_bits;
        logic               status;
        logic               sign;
        logic signed [10:0] exp;
        logic [27:0]        mant;
    } norm_t;

    function automatic logic [4:0] clz28(input logic [27:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) begin
                n = 5'(27 - i);
            end
        end
        return n;
    endfunction

    // one restoring division step
    function automatic pipe_t div_step(input pipe_t p);
        pipe_t      r;
        logic       ge;
        logic [24:0] diff;
        r = p;
        if (p.op == OP_DIV && !p.spec) begin
            ge = (p.rem >= {1'b0, p.mb[23:0]});
            diff = ge ? (p.rem - {1'b0, p.mb[23:0]}) : p.rem;
            r.rem = {diff[23:0], 1'b0};
            r.mant = {p.mant[26:0], ge};
        end
        return r;
    endfunction

endpackage

### sv/fasmd_round.sv
// ----------------------------------------------------------------------------
// fasmd_round
// Normalize, denormalize and round-to-nearest-even of an unrounded result,
// three register stages, last stage is the output register.
// ----------------------------------------------------------------------------
module fasmd_round (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  fasmd_pkg::norm_t in_d,
    output logic             out_valid,
    output logic [31:0]      out_bits,
    output logic             out_status
);

    fasmd_pkg::norm_t n1_reg, n1_next;
    logic [4:0]       lsh_reg, lsh_next;
    logic [4:0]       rsh_reg, rsh_next;
    fasmd_pkg::norm_t n2_reg, n2_next;
    logic             valid_reg;
    logic [31:0]      bits_reg, bits_next;
    logic             status_reg, status_next;

    logic [4:0]         lz;
    logic signed [10:0] ediff;
    logic signed [10:0] rneed;
    logic               sticky;
    logic [9:0]         ef;
    logic               inc;
    logic [32:0]        packed_v;

    // stage 1: leading zero count and shift amounts
    always_comb begin
        n1_next = in_d;
        lz = fasmd_pkg::clz28(in_d.mant);
        ediff = in_d.exp - signed'({6'b0, lz});
        rneed = 11'sd1 - in_d.exp;
        lsh_next = '0;
        rsh_next = '0;
        if (ediff >= 11'sd1) begin
            lsh_next = lz;
            n1_next.exp = ediff;
        end else if (in_d.exp >= 11'sd1) begin
            lsh_next = 5'(in_d.exp - 11'sd1);
            n1_next.exp = 11'sd1;
        end else begin
            rsh_next = (rneed > 11'sd31) ? 5'd31 : 5'(rneed);
            n1_next.exp = 11'sd1;
        end
    end

    // stage 2: shift, right shift keeps a sticky bit
    always_comb begin
        n2_next = n1_reg;
        sticky = |(n1_reg.mant & ~({28{1'b1}} << rsh_reg));
        if (rsh_reg != 5'd0) begin
            n2_next.mant = (n1_reg.mant >> rsh_reg) | {27'b0, sticky};
        end else begin
            n2_next.mant = n1_reg.mant << lsh_reg;
        end
    end

    // stage 3: round, carry may ripple into the exponent field
    always_comb begin
        ef = n2_reg.mant[27] ? n2_reg.exp[9:0] : 10'd0;
        inc = n2_reg.mant[3] & ((|n2_reg.mant[2:0]) | n2_reg.mant[4]);
        packed_v = {ef, n2_reg.mant[26:4]} + {32'b0, inc};
        status_next = n2_reg.spec & n2_reg.status;
        if (n2_reg.spec) begin
            bits_next = n2_reg.spec_bits;
        end else if (packed_v[32:23] >= 10'd255) begin
            bits_next = {n2_reg.sign, fasmd_pkg::INF_MAG};
        end else begin
            bits_next = {n2_reg.sign, packed_v[30:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_reg.valid <= 1'b0;
            n2_reg.valid <= 1'b0;
            valid_reg <= 1'b0;
        end else if (en) begin
            n1_reg <= n1_next;
            n2_reg <= n2_next;
            valid_reg <= n2_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lsh_reg <= lsh_next;
            rsh_reg <= rsh_next;
            bits_reg <= bits_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_bits = bits_reg;
    assign out_status = status_reg;

endmodule

### sv/float_add_sub_mul_div_unit.sv
// ----------------------------------------------------------------------------
// float_add_sub_mul_div_unit
// Pipelined IEEE-754 binary32 add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the output side does not stall and
// returns one result per request, in order. The depth is set by the
// divider, a restoring array that resolves one of 28 quotient bits per
// stage; add and multiply requests travel the same stages so order is
// kept. Any stall at the output holds the whole pipeline. Rounding is
// nearest-even with subnormals; NaN results are the canonical quiet NaN and
// a zero divisor returns 0 with the status flag set.
module float_add_sub_mul_div_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] operand_a, [63:32] operand_b
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_bits
    output logic        m_tuser    // [0] status
);

    fasmd_pkg::pipe_t s1_reg, s1_next;
    fasmd_pkg::pipe_t s2_reg, s2_next;
    fasmd_pkg::pipe_t s3_reg, s3_next;
    fasmd_pkg::pipe_t s4_reg, s4_next;
    fasmd_pkg::pipe_t dv_reg  [fasmd_pkg::DIV_BITS-2];
    fasmd_pkg::pipe_t dv_next [fasmd_pkg::DIV_BITS-2];
    fasmd_pkg::norm_t rnd_in;
    logic             adv;

    logic [31:0] a, bx;
    logic        sa, sb, nan_a, nan_b, inf_a, inf_b, z_a, z_b;
    logic [7:0]  exe_a, exe_b;
    logic [23:0] man_a, man_b;
    logic [4:0]  lz_a, lz_b;

    logic [7:0]         d;
    logic [26:0]        b27, bal;
    logic               lost;
    logic [23:0]        nma, nmb;
    logic signed [10:0] xa, xb;
    logic [27:0]        sum;

    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: decode, special operands, swap for add
    always_comb begin
        a = s_tdata[31:0];
        bx = s_tdata[63:32] ^ ((s_tuser == fasmd_pkg::OP_SUB) ? fasmd_pkg::SIGN_BIT : 32'b0);
        sa = a[31];
        sb = bx[31];
        nan_a = (a[30:23] == 8'hff) && (a[22:0] != 23'b0);
        nan_b = (bx[30:23] == 8'hff) && (bx[22:0] != 23'b0);
        inf_a = (a[30:0] == fasmd_pkg::INF_MAG);
        inf_b = (bx[30:0] == fasmd_pkg::INF_MAG);
        z_a = (a[30:0] == 31'b0);
        z_b = (bx[30:0] == 31'b0);
        exe_a = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        exe_b = (bx[30:23] == 8'd0) ? 8'd1 : bx[30:23];
        man_a = {a[30:23] != 8'd0, a[22:0]};
        man_b = {bx[30:23] != 8'd0, bx[22:0]};
        lz_a = fasmd_pkg::clz28({man_a, 4'b0});
        lz_b = fasmd_pkg::clz28({man_b, 4'b0});

        s1_next = '0;
        s1_next.valid = s_tvalid;
        s1_next.op = s_tuser;
        s1_next.lza = lz_a;
        s1_next.lzb = lz_b;
        s1_next.sign = sa ^ sb;
        s1_next.exa = exe_a;
        s1_next.exb = exe_b;
        s1_next.ma = {3'b0, man_a};
        s1_next.mb = {3'b0, man_b};

        case (s_tuser)
            fasmd_pkg::OP_ADD, fasmd_pkg::OP_SUB: begin
                if (exe_a < exe_b) begin
                    s1_next.sign = sb;
                    s1_next.sign_b = sa;
                    s1_next.exa = exe_b;
                    s1_next.exb = exe_a;
                    s1_next.ma = {3'b0, man_b};
                    s1_next.mb = {3'b0, man_a};
                end else begin
                    s1_next.sign = sa;
                    s1_next.sign_b = sb;
                end
                s1_next.spec = nan_a || nan_b || inf_a || inf_b || z_a || z_b;
                if (nan_a || nan_b) begin
                    s1_next.spec_bits = fasmd_pkg::QNAN_BITS;
                end else if (inf_a) begin
                    s1_next.spec_bits = (inf_b && sa != sb) ? fasmd_pkg::QNAN_BITS : a;
                end else if (inf_b) begin
                    s1_next.spec_bits = bx;
                end else if (z_a && z_b) begin
                    s1_next.spec_bits = (sa & sb) ? fasmd_pkg::SIGN_BIT : 32'b0;
                end else if (z_a) begin
                    s1_next.spec_bits = bx;
                end else begin
                    s1_next.spec_bits = a;
                end
            end
            fasmd_pkg::OP_MUL: begin
                s1_next.spec = nan_a || nan_b || inf_a || inf_b || z_a || z_b;
                if (nan_a || nan_b) begin
                    s1_next.spec_bits = fasmd_pkg::QNAN_BITS;
                end else if (inf_a || inf_b) begin
                    s1_next.spec_bits = (z_a || z_b) ? fasmd_pkg::QNAN_BITS
                                                     : {sa ^ sb, fasmd_pkg::INF_MAG};
                end else begin
                    s1_next.spec_bits = {sa ^ sb, 31'b0};
                end
            end
            default: begin
                s1_next.spec = nan_a || nan_b || inf_a || inf_b || z_a || z_b;
                if (z_b) begin
                    s1_next.spec_bits = 32'b0;
                    s1_next.status = 1'b1;
                end else if (nan_a || nan_b) begin
                    s1_next.spec_bits = fasmd_pkg::QNAN_BITS;
                end else if (inf_a) begin
                    s1_next.spec_bits = inf_b ? fasmd_pkg::QNAN_BITS
                                              : {sa ^ sb, fasmd_pkg::INF_MAG};
                end else begin
                    s1_next.spec_bits = {sa ^ sb, 31'b0};
                end
            end
        endcase
    end

    // stage 2: align for add, normalize significands for mul and div
    always_comb begin
        s2_next = s1_reg;
        d = s1_reg.exa - s1_reg.exb;
        b27 = {s1_reg.mb[23:0], 3'b0};
        lost = |(b27 & ~({27{1'b1}} << d[4:0]));
        if (d >= 8'd27) begin
            bal = {26'b0, |b27};
        end else begin
            bal = (b27 >> d[4:0]) | {26'b0, lost};
        end
        nma = s1_reg.ma[23:0] << s1_reg.lza;
        nmb = s1_reg.mb[23:0] << s1_reg.lzb;
        xa = signed'({3'b0, s1_reg.exa}) - signed'({6'b0, s1_reg.lza});
        xb = signed'({3'b0, s1_reg.exb}) - signed'({6'b0, s1_reg.lzb});
        case (s1_reg.op)
            fasmd_pkg::OP_ADD, fasmd_pkg::OP_SUB: begin
                s2_next.ma = {s1_reg.ma[23:0], 3'b0};
                s2_next.mb = bal;
                s2_next.exp = signed'({3'b0, s1_reg.exa}) + 11'sd1;
            end
            fasmd_pkg::OP_MUL: begin
                s2_next.ma = {3'b0, nma};
                s2_next.mb = {3'b0, nmb};
                s2_next.exp = xa + xb - 11'sd126;
            end
            default: begin
                s2_next.ma = {3'b0, nma};
                s2_next.mb = {3'b0, nmb};
                s2_next.rem = {1'b0, nma};
                s2_next.mant = '0;
                s2_next.exp = xa - xb + 11'sd127;
            end
        endcase
    end

    // stage 3: add or subtract, multiply, first divide step
    always_comb begin
        s3_next = fasmd_pkg::div_step(s2_reg);
        sum = {1'b0, s2_reg.ma} + {1'b0, s2_reg.mb};
        case (s2_reg.op)
            fasmd_pkg::OP_ADD, fasmd_pkg::OP_SUB: begin
                if (s2_reg.sign == s2_reg.sign_b) begin
                    s3_next.mant = sum;
                end else if (s2_reg.ma >= s2_reg.mb) begin
                    s3_next.mant = {1'b0, s2_reg.ma - s2_reg.mb};
                end else begin
                    s3_next.mant = {1'b0, s2_reg.mb - s2_reg.ma};
                    s3_next.sign = s2_reg.sign_b;
                end
                // exact cancellation gives +0
                if (s2_reg.sign != s2_reg.sign_b && s2_reg.ma == s2_reg.mb && !s2_reg.spec) begin
                    s3_next.spec = 1'b1;
                    s3_next.spec_bits = 32'b0;
                end
            end
            fasmd_pkg::OP_MUL: begin
                s3_next.prod = s2_reg.ma[23:0] * s2_reg.mb[23:0];
            end
            default: begin
            end
        endcase
    end

    // stage 4: fold product to 28 bits with sticky, second divide step
    always_comb begin
        s4_next = fasmd_pkg::div_step(s3_reg);
        if (s3_reg.op == fasmd_pkg::OP_MUL) begin
            s4_next.mant = {s3_reg.prod[47:21], |s3_reg.prod[20:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
            s3_reg.valid <= 1'b0;
            s4_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

    // remaining divider stages
    for (genvar g = 0; g < fasmd_pkg::DIV_BITS - 2; g++) begin : g_div
        if (g == 0) begin : g_first
            assign dv_next[g] = fasmd_pkg::div_step(s4_reg);
        end else begin : g_rest
            assign dv_next[g] = fasmd_pkg::div_step(dv_reg[g-1]);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[g].valid <= 1'b0;
            end else if (adv) begin
                dv_reg[g] <= dv_next[g];
            end
        end
    end

    always_comb begin
        rnd_in.valid = dv_reg[fasmd_pkg::DIV_BITS-3].valid;
        rnd_in.spec = dv_reg[fasmd_pkg::DIV_BITS-3].spec;
        rnd_in.spec_bits = dv_reg[fasmd_pkg::DIV_BITS-3].spec_bits;
        rnd_in.status = dv_reg[fasmd_pkg::DIV_BITS-3].status;
        rnd_in.sign = dv_reg[fasmd_pkg::DIV_BITS-3].sign;
        rnd_in.exp = dv_reg[fasmd_pkg::DIV_BITS-3].exp;
        rnd_in.mant = dv_reg[fasmd_pkg::DIV_BITS-3].mant;
        // nonzero remainder goes into the sticky bit
        if (dv_reg[fasmd_pkg::DIV_BITS-3].op == fasmd_pkg::OP_DIV) begin
            rnd_in.mant[0] = dv_reg[fasmd_pkg::DIV_BITS-3].mant[0]
                           | (dv_reg[fasmd_pkg::DIV_BITS-3].rem != 25'b0);
        end
    end

    fasmd_round u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_d       (rnd_in),
        .out_valid  (m_tvalid),
        .out_bits   (m_tdata),
        .out_status (m_tuser)
    );

`ifndef SYNTHESIS
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 32'b0)
        else $error("division by zero result not zero");
    a_nan_canonical: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[30:23] == 8'hff && m_tdata[22:0] != 23'b0
        |-> m_tdata == fasmd_pkg::QNAN_BITS)
        else $error("non canonical nan result");
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the binary32 add / subtract / multiply / divide
// pipeline: directed corner operands, a long output stall, then random
// requests biased toward special encodings, with random idling on both
// sides. Every result is compared against a bit-exact integer predictor.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct {
        logic [31:0] bits;
        logic        status;
    } fp_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // [31:0] operand_a, [63:32] operand_b
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] result_bits
    logic        m_tuser;   // [0] status

    fp_result_t pending_results[$];
    int  mismatch_count = 0;
    bit  calm = 0;        // no idling on either side
    int  hold_cycles = 0; // receiver hold-off request

    float_add_sub_mul_div_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // ---------------- predictor ----------------
    function automatic bit f_is_nan(logic [31:0] x);
        return x[30:0] > fasmd_pkg::INF_MAG;
    endfunction
    function automatic bit f_is_inf(logic [31:0] x);
        return x[30:0] == fasmd_pkg::INF_MAG;
    endfunction
    function automatic bit f_is_zero(logic [31:0] x);
        return x[30:0] == 31'd0;
    endfunction

    function automatic void split_float(input logic [31:0] x, output logic [63:0] m,
                                        output int e);
        if (x[30:23] == 8'd0) begin
            m = {41'd0, x[22:0]};
            e = -149;
        end else begin
            m = {40'd0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] round_to_single(logic sign, logic [63:0] m, int e);
        int p, q, sh, ex;
        logic [63:0] mm, rb, st;
        logic [31:0] s;
        s = sign ? fasmd_pkg::SIGN_BIT : 32'd0;
        rb = 0;
        st = 0;
        p = 63;
        while (m[p] == 1'b0) p--;
        q = p + e - 23;
        if (q < -149) q = -149;
        sh = q - e;
        if (sh <= 0) begin
            mm = m << (-sh);
        end else if (sh < 64) begin
            mm = m >> sh;
            rb = (m >> (sh - 1)) & 64'd1;
            st = m & ((64'd1 << (sh - 1)) - 64'd1);
        end else if (sh == 64) begin
            mm = 0;
            rb = m >> 63;
            st = m & 64'h7fff_ffff_ffff_ffff;
        end else begin
            mm = 0;
            st = 1;
        end
        if (rb != 0 && (st != 0 || mm[0])) begin
            mm = mm + 64'd1;
            if (mm == (64'd1 << 24)) begin
                mm = mm >> 1;
                q = q + 1;
            end
        end
        if (mm == 0) return s;
        if (mm >= 64'h80_0000) begin
            ex = q + 150;
            if (ex >= 255) return s | {1'b0, fasmd_pkg::INF_MAG};
            return s | (32'(ex) << 23) | {9'd0, mm[22:0]};
        end
        return s | mm[31:0];
    endfunction

    function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b);
        logic sa, sb, ts;
        logic [63:0] ma, mb, tm, lost;
        int ea, eb, te, d;
        sa = a[31];
        sb = b[31];
        if (f_is_nan(a) || f_is_nan(b)) return fasmd_pkg::QNAN_BITS;
        if (f_is_inf(a)) begin
            if (f_is_inf(b) && sa != sb) return fasmd_pkg::QNAN_BITS;
            return a;
        end
        if (f_is_inf(b)) return b;
        if (f_is_zero(a) && f_is_zero(b)) return (sa & sb) ? fasmd_pkg::SIGN_BIT : 32'd0;
        if (f_is_zero(a)) return b;
        if (f_is_zero(b)) return a;
        split_float(a, ma, ea);
        split_float(b, mb, eb);
        ma = ma << 38; ea -= 38;
        mb = mb << 38; eb -= 38;
        if (ea < eb) begin
            tm = ma; te = ea; ts = sa;
            ma = mb; ea = eb; sa = sb;
            mb = tm; eb = te; sb = ts;
        end
        d = ea - eb;
        if (d >= 63) begin
            mb = 64'd1;
        end else if (d > 0) begin
            lost = mb & ((64'd1 << d) - 64'd1);
            mb = (mb >> d) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        if (sa == sb) return round_to_single(sa, ma + mb, ea);
        if (ma == mb) return 32'd0;
        if (ma > mb) return round_to_single(sa, ma - mb, ea);
        return round_to_single(sb, mb - ma, ea);
    endfunction

    function automatic logic [31:0] predict_product(logic [31:0] a, logic [31:0] b);
        logic s;
        logic [63:0] ma, mb;
        int ea, eb;
        s = a[31] ^ b[31];
        if (f_is_nan(a) || f_is_nan(b)) return fasmd_pkg::QNAN_BITS;
        if (f_is_inf(a) || f_is_inf(b)) begin
            if (f_is_zero(a) || f_is_zero(b)) return fasmd_pkg::QNAN_BITS;
            return {s, fasmd_pkg::INF_MAG};
        end
        if (f_is_zero(a) || f_is_zero(b)) return {s, 31'd0};
        split_float(a, ma, ea);
        split_float(b, mb, eb);
        return round_to_single(s, ma * mb, ea + eb);
    endfunction

    function automatic logic [31:0] predict_quotient(logic [31:0] a, logic [31:0] b);
        logic s;
        logic [63:0] ma, mb, qt;
        int ea, eb;
        s = a[31] ^ b[31];
        if (f_is_nan(a) || f_is_nan(b)) return fasmd_pkg::QNAN_BITS;
        if (f_is_inf(a)) begin
            if (f_is_inf(b)) return fasmd_pkg::QNAN_BITS;
            return {s, fasmd_pkg::INF_MAG};
        end
        if (f_is_inf(b) || f_is_zero(a)) return {s, 31'd0};
        split_float(a, ma, ea);
        split_float(b, mb, eb);
        while (ma[23] == 1'b0) begin ma = ma << 1; ea--; end
        while (mb[23] == 1'b0) begin mb = mb << 1; eb--; end
        ma = ma << 40;
        qt = ma / mb;
        if (ma % mb != 0) qt[0] = 1'b1;
        return round_to_single(s, qt, ea - 40 - eb);
    endfunction

    function automatic fp_result_t predict_fp_op(logic [1:0] op, logic [31:0] a,
                                                 logic [31:0] b);
        fp_result_t r;
        r.status = 1'b0;
        case (op)
            fasmd_pkg::OP_ADD: r.bits = predict_sum(a, b);
            fasmd_pkg::OP_SUB: r.bits = predict_sum(a, b ^ fasmd_pkg::SIGN_BIT);
            fasmd_pkg::OP_MUL: r.bits = predict_product(a, b);
            default: begin
                if (f_is_zero(b)) begin
                    r.bits = 32'd0;
                    r.status = 1'b1;
                end else begin
                    r.bits = predict_quotient(a, b);
                end
            end
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------
    task automatic send_request(logic [1:0] op, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.insert(pending_results.size(), predict_fp_op(op, a, b));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v[30:23] = 8'hff;                  // inf or nan
            1: v[30:23] = 8'h00;                  // zero or subnormal
            2: v[30:0]  = 31'd0;                  // signed zero
            3: v[30:23] = 8'($urandom_range(250, 254));
            4: v[30:23] = 8'($urandom_range(1, 6));
            default: v[30:23] = 8'($urandom_range(100, 154));
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [31:0] vals[12];
        vals = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                 32'h7fc0_0000, 32'hffff_ffff, 32'h0000_0001, 32'h007f_ffff,
                 32'h7f7f_ffff, 32'h3f80_0000, 32'hbf80_0000, 32'h0080_0000};
        send_request(fasmd_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000);   // -0 + -0
        send_request(fasmd_pkg::OP_ADD, 32'h0000_0000, 32'h8000_0000);
        send_request(fasmd_pkg::OP_SUB, 32'h3fc0_0000, 32'h3fc0_0000);   // x - x
        send_request(fasmd_pkg::OP_SUB, 32'h7f80_0000, 32'h7f80_0000);   // inf - inf
        send_request(fasmd_pkg::OP_ADD, 32'h7f7f_ffff, 32'h7f7f_ffff);   // overflow
        send_request(fasmd_pkg::OP_MUL, 32'h0000_0000, 32'hff80_0000);   // 0 * inf
        send_request(fasmd_pkg::OP_MUL, 32'h0000_0001, 32'h3f00_0000);   // tie underflow
        send_request(fasmd_pkg::OP_MUL, 32'h7f7f_ffff, 32'h4000_0000);
        send_request(fasmd_pkg::OP_DIV, 32'h7f80_0000, 32'hff80_0000);   // inf / inf
        send_request(fasmd_pkg::OP_DIV, 32'h7fc0_0000, 32'h8000_0000);   // nan over zero
        send_request(fasmd_pkg::OP_DIV, 32'h3f80_0000, 32'h0000_0000);
        send_request(fasmd_pkg::OP_DIV, 32'h3f80_0000, 32'h7fff_ffff);   // nan divisor
        send_request(fasmd_pkg::OP_DIV, 32'h3f80_0000, 32'h4040_0000);
        send_request(fasmd_pkg::OP_DIV, 32'h0000_0001, 32'h7f7f_ffff);
        send_request(fasmd_pkg::OP_ADD, 32'h3f80_0000, 32'h3380_0000);   // tie to even
        send_request(fasmd_pkg::OP_SUB, 32'h0080_0000, 32'h007f_ffff);
        for (int i = 0; i < 8; i++)
            send_request(2'(i), vals[$urandom_range(11)], vals[$urandom_range(11)]);
        wait_drained();
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) begin
            calm = (i >= 300 && i < 500);
            send_request(2'($urandom_range(3)), pick_operand(), pick_operand());
        end
        calm = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 120;
        for (int i = 0; i < 100; i++)
            send_request(2'($urandom_range(3)), pick_operand(), pick_operand());
        wait_drained();
    endtask

    // ---------------- result side ----------------
    always @(posedge aclk) begin
        fp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result bits=%h status=%b", m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.bits || m_tuser !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h/%b actual %h/%b",
                                 want.bits, want.status, m_tdata, m_tuser);
                end
            end
        end
    end

    // receiver: random stall, long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = fasmd_pkg::OP_ADD;
        aresetn  = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(1700);
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
sv/fasmd_pkg.sv
sv/fasmd_round.sv
sv/float_add_sub_mul_div_unit.sv
tb/tb_top.sv
